/* src/signed_integer_to_radix_digits_assert.svh */
// Assertion macros shared by the radix conversion RTL.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a property holds on every rising clock edge outside reset.
`define SITRD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);
// Checks that a condition never holds on a rising clock edge outside reset.
`define SITRD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`SITRD_ASSERT_CLK(lbl, clk, rstn, !(cond), msg)
`else
`define SITRD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SITRD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* src/sitrd_pkg.sv */
// Shared constants and types for the signed integer to radix digits block.
`timescale 1ns / 1ps
package sitrd_pkg;

	localparam int VALUE_WIDTH  = 32;
	localparam int MAX_SYMBOLS  = 32;
	localparam int REG_SYMBOLS  = 32;
	localparam int SYM_W        = 8;
	localparam int BASE_W       = 6;
	localparam int DIGIT_W      = $clog2(REG_SYMBOLS);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int SYMS_PER_REG = CFG_DATA_W / SYM_W;
	localparam int NUM_SYM_REGS = REG_SYMBOLS / SYMS_PER_REG;
	localparam int SYM_REG_IDX_W = $clog2(NUM_SYM_REGS);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_FIRST = 3'd1;

	// Reset contents: radix ten with the decimal digits as alphabet.
	localparam logic [BASE_W-1:0] BASE_SIZE_RESET = 6'd10;
	localparam logic [NUM_SYM_REGS*CFG_DATA_W-1:0] SYM_RESET = {
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_3938,
		64'h3736_3534_3332_3130
	};

	localparam logic [SYM_W-1:0] SIGN_CHAR = 8'h2D;
	localparam logic [SYM_W-1:0] PLUS_CHAR = 8'h2B;

	// Divider: DIV_BITS quotient bits per cycle.
	localparam int DIV_BITS   = 8;
	localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W      = DIV_CYCLES * DIV_BITS;
	localparam int DIVCNT_W   = $clog2(DIV_CYCLES + 1);

	localparam int MAX_DIGITS = VALUE_WIDTH;
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	typedef struct packed {
		logic ready;
		logic ok;
	} chk_status_t;

endpackage

/* src/sitrd_if.sv */
// Valid/ready channel interfaces for input values, output symbols and configuration.
`timescale 1ns / 1ps
interface sitrd_in_if;
	import sitrd_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sitrd_out_if;
	import sitrd_pkg::*;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic             bad_base;
	modport source (output valid, output symbol, output last, output bad_base, input ready);
	modport sink (input valid, input symbol, input last, input bad_base, output ready);
endinterface

interface sitrd_cfg_if;
	import sitrd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/signed_integer_to_radix_digits.sv */
// Top level: converts signed values into radix text words under a small sequencer.
`timescale 1ns / 1ps
// Each digit takes one pass through the shared divider (a start step, then steps of eight
// quotient bits). Then words go out one per cycle while the receiver keeps ready high: a
// sign word if negative, then the digits. The next value is taken once the last word has
// been handed to the output register.
// A bad alphabet or radix size gives one flagged word per value, a zero symbol marked last and bad_base.
// Reset is asynchronous, active low, loads radix ten with decimal digits; it and each write start a sweep of all 32 symbols with din.ready low.
`include "signed_integer_to_radix_digits_assert.svh"
module signed_integer_to_radix_digits (
	input logic         clk,
	input logic         arst_n,
	sitrd_in_if.sink    din,
	sitrd_out_if.source dout,
	sitrd_cfg_if.sink   cfg
);
	import sitrd_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_BAD  = 3'd4;

	// Configuration registers.
	logic [BASE_W-1:0]             base_size_q;
	logic [CFG_DATA_W-1:0]         sym_reg_q [NUM_SYM_REGS];
	logic [REG_SYMBOLS*SYM_W-1:0]  symbols_flat;
	logic                          cfg_wr;
	logic [CFG_IDX_W-1:0]          sym_off;

	// Sequencer and digit store.
	logic [2:0]             state_q;
	logic [IDX_W-1:0]       nd_q;
	logic [IDX_W-1:0]       rd_q;
	logic [DIGIT_W-1:0]     digit_q [MAX_DIGITS];
	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	logic [VALUE_WIDTH-1:0] value_u;
	logic                   value_neg;
	logic [VALUE_WIDTH-1:0] mag;

	// Output register.
	logic             out_valid_q;
	logic [SYM_W-1:0] out_symbol_q;
	logic             out_last_q;
	logic             out_bad_q;

	// Divider hookup.
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [BASE_W-1:0]      div_rem;

	chk_status_t chk_status;

	// Configuration writes are always taken; the alphabet sweep restarts on each of them.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign sym_off   = cfg.index - CFG_SYMBOLS_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q <= BASE_SIZE_RESET;
			for (int i = 0; i < NUM_SYM_REGS; i++) begin
				sym_reg_q[i] <= SYM_RESET[i*CFG_DATA_W +: CFG_DATA_W];
			end
		end else if (cfg_wr) begin
			if (cfg.index == CFG_BASE_SIZE) begin
				base_size_q <= cfg.data[BASE_W-1:0];
			end else if (cfg.index >= CFG_SYMBOLS_FIRST
					&& int'(sym_off) < NUM_SYM_REGS) begin
				sym_reg_q[sym_off[SYM_REG_IDX_W-1:0]] <= cfg.data;
			end
		end
	end

	for (genvar g = 0; g < NUM_SYM_REGS; g++) begin : g_flat
		assign symbols_flat[g*CFG_DATA_W +: CFG_DATA_W] = sym_reg_q[g];
	end

	sitrd_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr),
		.base_size (base_size_q),
		.symbols   (symbols_flat),
		.status    (chk_status)
	);

	// The magnitude is taken in unsigned arithmetic, so the most negative value
	// maps onto its true size rather than overflowing.
	assign value_u   = din.value;
	assign value_neg = value_u[VALUE_WIDTH-1];
	assign mag       = value_neg ? (~value_u + 1'b1) : value_u;

	assign din.ready = (state_q == ST_IDLE) && chk_status.ready;
	assign in_acc    = din.valid && din.ready;
	assign out_free  = !out_valid_q || dout.ready;
	// A word is handed to the output register in every emitting state once it is free.
	assign out_load  = out_free
		&& (state_q == ST_SIGN || state_q == ST_EMIT || state_q == ST_BAD);

	// The divider is started on a good value, and again after every digit
	// while the quotient is still non-zero.
	assign div_start    = (in_acc && chk_status.ok)
		|| (state_q == ST_DIV && div_done && div_quot != '0);
	assign div_dividend = (state_q == ST_IDLE) ? mag : div_quot;

	sitrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (base_size_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	logic neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nd_q        <= '0;
			rd_q        <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q   <= value_neg;
						nd_q    <= '0;
						state_q <= chk_status.ok ? ST_DIV : ST_BAD;
					end
				end
				ST_DIV: begin
					// Digits come out least significant first and are read back in reverse.
					if (div_done) begin
						if (div_quot == '0) begin
							rd_q    <= nd_q;
							state_q <= neg_q ? ST_SIGN : ST_EMIT;
						end else begin
							nd_q <= nd_q + 1'b1;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (rd_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_q <= rd_q - 1'b1;
						end
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			digit_q[nd_q] <= div_rem[DIGIT_W-1:0];
		end
	end

	// Output word payload; loaded whenever the sequencer hands over a word.
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				ST_SIGN: begin
					out_symbol_q <= SIGN_CHAR;
					out_last_q   <= 1'b0;
					out_bad_q    <= 1'b0;
				end
				ST_EMIT: begin
					out_symbol_q <= symbols_flat[digit_q[rd_q]*SYM_W +: SYM_W];
					out_last_q   <= (rd_q == '0);
					out_bad_q    <= 1'b0;
				end
				ST_BAD: begin
					out_symbol_q <= '0;
					out_last_q   <= 1'b1;
					out_bad_q    <= 1'b1;
				end
				default: begin
					out_symbol_q <= out_symbol_q;
				end
			endcase
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.symbol   = out_symbol_q;
	assign dout.last     = out_last_q;
	assign dout.bad_base = out_bad_q;

	`SITRD_ASSERT_CLK(a_one_value_at_a_time, clk, arst_n, in_acc |=> !din.ready, "input taken while busy")
	`SITRD_ASSERT_CLK(a_rem_below_radix, clk, arst_n, div_done |-> (div_rem < base_size_q), "digit not below radix")
	`SITRD_ASSERT_NEVER(a_bad_word_form, clk, arst_n, dout.valid && dout.bad_base && (!dout.last || (|dout.symbol)), "malformed bad base word")

endmodule

/* src/sitrd_div.sv */
// Iterative restoring divider by a small radix, several quotient bits per cycle.
`timescale 1ns / 1ps
module sitrd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sitrd_pkg::VALUE_WIDTH-1:0] dividend,
	input  logic [sitrd_pkg::BASE_W-1:0]      radix,
	output logic                            done,
	output logic [sitrd_pkg::VALUE_WIDTH-1:0] quot,
	output logic [sitrd_pkg::BASE_W-1:0]      rem
);
	import sitrd_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]    num_q;
	logic [BASE_W-1:0]   rem_q;
	logic [DIV_W-1:0]    num_next;
	logic [BASE_W-1:0]   rem_next;

	// Each step brings down one dividend bit and shifts in one quotient bit.
	always_comb begin
		logic [BASE_W:0] t;
		logic            ge;
		num_next = num_q;
		rem_next = rem_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {rem_next, num_next[DIV_W-1]};
			ge = (t >= {1'b0, radix});
			if (ge) begin
				rem_next = BASE_W'(t - {1'b0, radix});
			end else begin
				rem_next = t[BASE_W-1:0];
			end
			num_next = {num_next[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIVCNT_W'(DIV_CYCLES - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIVCNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= DIV_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_next;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign quot = num_q[VALUE_WIDTH-1:0];
	assign rem  = rem_q;

endmodule

/* src/sitrd_chk.sv */
// Alphabet checker: sweeps the symbol table for forbidden and repeated symbols.
`timescale 1ns / 1ps
module sitrd_chk (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           restart,
	input  logic [sitrd_pkg::BASE_W-1:0]                   base_size,
	input  logic [sitrd_pkg::REG_SYMBOLS*sitrd_pkg::SYM_W-1:0] symbols,
	output sitrd_pkg::chk_status_t                         status
);
	import sitrd_pkg::*;

	logic               busy_q;
	logic               err_q;
	logic [DIGIT_W-1:0] idx_q;
	logic [SYM_W-1:0]   cur;
	logic               in_range;
	logic               forbidden;
	logic               dup;
	logic               size_ok;

	assign cur       = symbols[idx_q*SYM_W +: SYM_W];
	assign in_range  = BASE_W'(idx_q) < base_size;
	assign forbidden = (cur == '0) || (cur == PLUS_CHAR) || (cur == SIGN_CHAR);

	// Compare the current symbol with every later symbol inside the alphabet.
	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < REG_SYMBOLS; j++) begin
			if (j > int'(idx_q) && j < int'(base_size)
					&& symbols[j*SYM_W +: SYM_W] == cur) begin
				dup = 1'b1;
			end
		end
	end

	assign size_ok = (int'(base_size) >= 2) && (int'(base_size) <= MAX_SYMBOLS)
		&& (int'(base_size) <= REG_SYMBOLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			err_q  <= 1'b0;
			idx_q  <= '0;
		end else if (restart) begin
			busy_q <= 1'b1;
			err_q  <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (in_range && (forbidden || dup)) begin
				err_q <= 1'b1;
			end
			if (idx_q == DIGIT_W'(REG_SYMBOLS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign status.ready = !busy_q;
	assign status.ok    = size_ok && !err_q;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the signed integer to radix digits converter.
`timescale 1ns / 1ps
module testbench;
	import sitrd_pkg::*;

	// Timing of the run. The block handles one value at a time, so the worst value
	// (radix two, most negative number) gives the longest wait for its last word.
	localparam int RESET_CYCLES = 7;
	localparam int IDLE_MAX     = 8;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 370;
	localparam int TIMEOUT_NS   = 2_000_000;
	localparam int REPORT_MAX   = 10;

	// Writes to indexes above the alphabet banks are accepted and change no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST =
		CFG_IDX_W'(CFG_SYMBOLS_FIRST + NUM_SYM_REGS);

	// One output word as the block presents it.
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
		logic             bad_base;
	} text_word_t;

	// The scoreboard keeps its own copy of the registers, spells out each value that
	// the block accepts and holds the words still to come, oldest first.
	class radix_text_scoreboard;
		logic [BASE_W-1:0]     radix;
		logic [CFG_DATA_W-1:0] sym_bank [NUM_SYM_REGS];
		text_word_t            pending_words [$];
		int                    mismatches;
		int                    values_seen;
		int                    words_seen;
		int                    rejected;

		function new();
			radix = BASE_SIZE_RESET;
			for (int j = 0; j < NUM_SYM_REGS; j++) begin
				sym_bank[j] = SYM_RESET[j*CFG_DATA_W +: CFG_DATA_W];
			end
			mismatches  = 0;
			values_seen = 0;
			words_seen  = 0;
			rejected    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_BASE_SIZE) begin
				radix = data[BASE_W-1:0];
			end else if (idx >= CFG_SYMBOLS_FIRST && idx < CFG_SPARE_FIRST) begin
				sym_bank[idx - CFG_SYMBOLS_FIRST] = data;
			end
		endfunction

		function logic [SYM_W-1:0] symbol_of(int k);
			return sym_bank[k / SYMS_PER_REG][(k % SYMS_PER_REG)*SYM_W +: SYM_W];
		endfunction

		// The alphabet must have at least two symbols, fit in the banks, and hold
		// only distinct symbols that are neither a sign nor a zero byte.
		function bit alphabet_ok();
			int n;
			logic [SYM_W-1:0] c;
			n = int'(radix);
			if (n < 2 || n > MAX_SYMBOLS || n > REG_SYMBOLS) return 1'b0;
			for (int i = 0; i < n; i++) begin
				c = symbol_of(i);
				if (c == 8'h00 || c == PLUS_CHAR || c == SIGN_CHAR) return 1'b0;
				for (int j = i + 1; j < n; j++) begin
					if (symbol_of(j) == c) return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void note_value(logic signed [VALUE_WIDTH-1:0] v);
			logic [VALUE_WIDTH-1:0] mag;
			logic [VALUE_WIDTH-1:0] r;
			logic [DIGIT_W-1:0]     digs [MAX_DIGITS];
			int                     nd;
			values_seen++;
			if (!alphabet_ok()) begin
				pending_words.push_back('{symbol: '0, last: 1'b1, bad_base: 1'b1});
				return;
			end
			// The magnitude is taken unsigned, so the most negative value needs no
			// extra bit.
			mag = v;
			if (v[VALUE_WIDTH-1]) mag = -mag;
			r  = VALUE_WIDTH'(radix);
			nd = 0;
			do begin
				digs[nd] = DIGIT_W'(mag % r);
				mag = mag / r;
				nd++;
			end while (mag != 0);
			if (v[VALUE_WIDTH-1]) begin
				pending_words.push_back('{symbol: SIGN_CHAR, last: 1'b0, bad_base: 1'b0});
			end
			for (int i = nd - 1; i >= 0; i--) begin
				pending_words.push_back('{symbol: symbol_of(digs[i]), last: (i == 0),
					bad_base: 1'b0});
			end
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= REPORT_MAX) $display("%t: %s", $realtime, what);
		endfunction

		function void check_word(logic [SYM_W-1:0] s, logic l, logic b);
			text_word_t want;
			words_seen++;
			if (b) rejected++;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word symbol=%02h last=%0b bad_base=%0b",
					s, l, b));
				return;
			end
			want = pending_words.pop_front();
			if (want.symbol !== s || want.last !== l || want.bad_base !== b) begin
				report($sformatf("word mismatch: expected symbol=%02h last=%0b bad_base=%0b, %s",
					want.symbol, want.last, want.bad_base,
					$sformatf("got symbol=%02h last=%0b bad_base=%0b", s, l, b)));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sitrd_in_if  din_if ();
	sitrd_out_if dout_if ();
	sitrd_cfg_if cfg_if ();

	signed_integer_to_radix_digits u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	radix_text_scoreboard  sb;
	logic [CFG_DATA_W-1:0] next_bank [NUM_SYM_REGS];
	// When calm is set, neither side idles, so the block runs back to back.
	bit                    calm;
	// A request for the receiver to hold off for a long stretch.
	bit                    hold_request;
	int                    reg_writes;
	int                    alphabets;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// The run ends here if the block stops making progress.
	initial begin
		#(TIMEOUT_NS);
		$display("signed_integer_to_radix_digits test failed");
		$finish;
	end

	// Receiver: takes output words with random stalls and hands each one to the
	// scoreboard. A pending hold-off keeps ready low for a long stretch, counted
	// here, while the sender keeps offering values.
	initial begin
		int stall;
		dout_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				dout_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
			if (stall != 0) begin
				dout_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			dout_if.ready = 1'b1;
			do @(posedge clk); while (!dout_if.valid);
			sb.check_word(dout_if.symbol, dout_if.last, dout_if.bad_base);
		end
	end

	// Offers one value after a random gap and waits until the block takes it. Valid
	// stays high between values offered back to back.
	task automatic push_value(input logic signed [VALUE_WIDTH-1:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
		@(negedge clk);
		if (gap != 0) begin
			din_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_if.valid = 1'b1;
		din_if.value = v;
		do @(posedge clk); while (!din_if.ready);
		sb.note_value(v);
	endtask

	// Lowers valid, then waits until every expected word has arrived, so that the
	// registers may be written with the block idle.
	task automatic settle();
		@(negedge clk);
		din_if.valid = 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic write_banks();
		for (int j = 0; j < NUM_SYM_REGS; j++) begin
			write_register(CFG_IDX_W'(CFG_SYMBOLS_FIRST + j), next_bank[j]);
		end
		alphabets++;
	endtask

	// Fills the banks with n distinct legal symbols, and junk beyond them, which the
	// block must ignore.
	function automatic void pick_alphabet(int n);
		bit               used [256];
		logic [SYM_W-1:0] c;
		for (int j = 0; j < NUM_SYM_REGS; j++) next_bank[j] = {$urandom(), $urandom()};
		for (int k = 0; k < n; k++) begin
			do c = SYM_W'($urandom_range(0, 255));
			while (used[c] || c == 8'h00 || c == PLUS_CHAR || c == SIGN_CHAR);
			used[c] = 1'b1;
			next_bank[k / SYMS_PER_REG][(k % SYMS_PER_REG)*SYM_W +: SYM_W] = c;
		end
	endfunction

	// Spoils one symbol of a legal alphabet: a sign, a zero byte or a repeat.
	function automatic void plant_flaw(int n);
		int               pos;
		int               other;
		logic [SYM_W-1:0] c;
		pos   = $urandom_range(0, n - 1);
		other = (pos + 1) % n;
		case ($urandom_range(0, 3))
			0: c = PLUS_CHAR;
			1: c = SIGN_CHAR;
			2: c = 8'h00;
			default: c = next_bank[other / SYMS_PER_REG][(other % SYMS_PER_REG)*SYM_W +: SYM_W];
		endcase
		next_bank[pos / SYMS_PER_REG][(pos % SYMS_PER_REG)*SYM_W +: SYM_W] = c;
	endfunction

	// Loads a fresh random setting and returns how many values to convert with it.
	// Most settings are legal; a few are raw noise or carry one planted flaw.
	task automatic random_config(output int items);
		int                    kind;
		int                    n;
		logic [CFG_DATA_W-1:0] base_word;
		kind = $urandom_range(0, 9);
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 6) : $urandom_range(2, MAX_SYMBOLS);
		pick_alphabet(n);
		if (kind == 0) begin
			n = $urandom_range(0, 63);
			for (int j = 0; j < NUM_SYM_REGS; j++) next_bank[j] = {$urandom(), $urandom()};
		end else if (kind == 1) begin
			plant_flaw(n);
		end
		// Bits above the radix field are ignored, so they are sometimes filled.
		base_word = CFG_DATA_W'(n);
		if ($urandom_range(0, 1) == 1) begin
			base_word = {$urandom(), $urandom()};
			base_word[BASE_W-1:0] = BASE_W'(n);
		end
		write_register(CFG_BASE_SIZE, base_word);
		write_banks();
		items = (kind < 2) ? 8 : 34;
	endtask

	// Values are a mix of full-width noise, small numbers, numbers of random length
	// and the edges around zero, the extremes and the radix itself.
	function automatic logic signed [VALUE_WIDTH-1:0] draw_value();
		logic signed [VALUE_WIDTH-1:0] v;
		int                            r;
		r = int'(sb.radix);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom();
			4, 5: v = int'($urandom_range(0, 600)) - 300;
			6: begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = -1;
					2: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
					3: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
					4: v = r;
					5: v = -r;
					6: v = r - 1;
					default: v = r * r;
				endcase
			end
			default: begin
				v = $urandom() >> $urandom_range(0, VALUE_WIDTH - 1);
				if ($urandom_range(0, 1) == 1) v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin
		int planned;
		int sent;
		int phase;
		sb           = new();
		calm         = 1'b0;
		hold_request = 1'b0;
		reg_writes   = 0;
		alphabets    = 1;
		arst_n       = 1'b0;
		din_if.valid = 1'b0;
		din_if.value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Decimal alphabet from reset: zero, one digit, the radix, and the extremes.
		push_value(0);
		push_value(1);
		push_value(-1);
		push_value(9);
		push_value(10);
		push_value(-10);
		push_value(32'sh7FFF_FFFF);
		push_value(32'sh8000_0000);
		settle();

		// Radix two: the most negative value gives the longest run of words. The spare
		// indexes are written with noise and must change nothing.
		for (int j = 0; j < NUM_SYM_REGS; j++) next_bank[j] = '0;
		next_bank[0] = 64'h0000_0000_0000_3130;
		write_register(CFG_BASE_SIZE, 64'd2);
		write_banks();
		for (int i = CFG_SPARE_FIRST; i < 2**CFG_IDX_W; i++) begin
			write_register(CFG_IDX_W'(i), {$urandom(), $urandom()});
		end
		push_value(32'sh8000_0000);
		push_value(32'sh7FFF_FFFF);
		push_value(0);
		push_value(-1);
		settle();

		// Radix thirty-two using every bank, with the symbols 0xFF and 0x01 in it.
		for (int k = 0; k < REG_SYMBOLS; k++) begin
			next_bank[k / SYMS_PER_REG][(k % SYMS_PER_REG)*SYM_W +: SYM_W] =
				(k == 0) ? 8'hFF : (k == 1) ? 8'h01 : SYM_W'(8'h40 + k);
		end
		write_register(CFG_BASE_SIZE, CFG_DATA_W'(MAX_SYMBOLS));
		write_banks();
		push_value(31);
		push_value(32);
		push_value(32'sh8000_0000);
		push_value(32'sh7FFF_FFFF);
		push_value(-1023);
		settle();

		// Radix sizes that are too small or too large are each rejected.
		write_register(CFG_BASE_SIZE, 64'd0);
		push_value(5);
		settle();
		write_register(CFG_BASE_SIZE, 64'd1);
		push_value(-5);
		settle();
		write_register(CFG_BASE_SIZE, CFG_DATA_W'(MAX_SYMBOLS + 1));
		push_value(5);
		settle();
		write_register(CFG_BASE_SIZE, 64'd63);
		push_value(5);
		settle();

		// A plus sign, a minus sign, a zero byte and a repeated symbol in a
		// three-symbol alphabet are each rejected. A sign just past the end of a
		// two-symbol alphabet is harmless.
		for (int j = 0; j < NUM_SYM_REGS; j++) next_bank[j] = '0;
		write_register(CFG_BASE_SIZE, 64'd3);
		next_bank[0] = 64'h0000_0000_0063_2B61;
		write_banks();
		push_value(7);
		settle();
		next_bank[0] = 64'h0000_0000_002D_6261;
		write_banks();
		push_value(-7);
		settle();
		next_bank[0] = 64'h0000_0000_0000_6261;
		write_banks();
		push_value(7);
		settle();
		next_bank[0] = 64'h0000_0000_0061_6261;
		write_banks();
		push_value(7);
		settle();
		write_register(CFG_BASE_SIZE, 64'd2);
		next_bank[0] = 64'h0000_0000_002D_6261;
		write_banks();
		push_value(-6);
		settle();

		// Random part: a fresh setting per phase, some phases without any idling,
		// and one phase in which the receiver holds off long enough to stall input.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			random_config(planned);
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 2) hold_request = 1'b1;
			for (int i = 0; i < planned && sent < RANDOM_ITEMS; i++) begin
				push_value(draw_value());
				sent++;
			end
			settle();
			phase++;
		end

		// Stray words would show up in this final stretch.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_words.size() != 0) begin
			sb.report($sformatf("%0d expected words never arrived", sb.pending_words.size()));
		end
		$display("Converted %0d values into %0d words under %0d alphabets (%0d rejected words).",
			sb.values_seen, sb.words_seen, alphabets, sb.rejected);
		$display("Made %0d register writes; %0d mismatches found.", reg_writes, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("signed_integer_to_radix_digits test passed");
		end else begin
			$display("signed_integer_to_radix_digits test failed");
		end
		$finish;
	end

endmodule
